FILE: rtl/content_length_message_framer_unit_assert.svh
// Assertion macros for the message framer.
`ifndef CONTENT_LENGTH_MESSAGE_FRAMER_UNIT_ASSERT_SVH
`define CONTENT_LENGTH_MESSAGE_FRAMER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define CLMF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CLMF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CLMF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CLMF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/clmf_pkg.sv
package clmf_pkg;

  localparam int MSG_W = 16;
  localparam logic [MSG_W-1:0] MAX_SIZE_RESET = 16'd4096;

  typedef logic [1:0] err_t;
  localparam err_t ERR_NONE     = 2'd0;
  localparam err_t ERR_NO_LEN   = 2'd1;
  localparam err_t ERR_TOO_LONG = 2'd2;

  localparam logic [1:0] PH_HDR  = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;

  localparam logic [1:0] VP_NONE  = 2'd0;
  localparam logic [1:0] VP_BLANK = 2'd1;
  localparam logic [1:0] VP_DIGIT = 2'd2;
  localparam logic [1:0] VP_DONE  = 2'd3;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [23:0] HDR_TAIL = {CH_CR, CH_LF, CH_CR};

  localparam logic [3:0] KEY_LEN = 4'd15;

  // Characters of "Content-Length:" by position.
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "C";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "L";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      4'd14:   c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/clmf_if.sv
interface clmf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface clmf_out_if;
  import clmf_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       in_body;
  logic       message_end;
  err_t       error_code;

  modport source (output valid, output out_byte, output in_body, output message_end,
                  output error_code, input ready);
  modport sink (input valid, input out_byte, input in_body, input message_end,
                input error_code, output ready);
endinterface

FILE: rtl/content_length_message_framer_unit.sv
// Each byte's result is registered in the output register when the byte is accepted.
// Throughput: one byte per cycle while the output is drained; the whole parser update is one registered step.
// A new byte is taken whenever the output register is empty or being drained.
// Reset (synchronous, rst_n low) starts a new message and sets the maximum
// message size to 4096; the output register comes up empty.
module content_length_message_framer_unit #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  clmf_in_if.sink                    in_chan,
  clmf_out_if.source                 out_chan,
  input  logic                       cfg_wr_en,
  input  logic [clmf_pkg::MSG_W-1:0] cfg_wr_data
);
  import clmf_pkg::*;

  localparam int SUM_W = ((LENGTH_BITS > MSG_W) ? LENGTH_BITS : MSG_W) + 2;
  localparam int MUL_W = LENGTH_BITS + 4;
  localparam logic [LENGTH_BITS-1:0] LEN_CAP = {LENGTH_BITS{1'b1}};

  logic [MSG_W-1:0]       max_size_r;
  logic [23:0]            recent_r, recent_nxt;
  logic [1:0]             phase_r, phase_nxt;
  logic [3:0]             match_r, match_nxt;
  logic [1:0]             vphase_r, vphase_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [MSG_W-1:0]       count_r, count_nxt;
  logic [MSG_W-1:0]       rem_r, rem_nxt;

  logic                   out_valid_r;
  logic [7:0]             out_byte_r;
  logic                   in_body_r, in_body_nxt;
  logic                   end_r, end_nxt;
  err_t                   err_r, err_nxt;

  logic                   accept;
  logic [7:0]             b;
  logic                   is_digit;
  logic [3:0]             digit;
  logic [3:0]             sc_match;
  logic [1:0]             sc_vphase;
  logic [LENGTH_BITS-1:0] sc_len;
  logic [MUL_W-1:0]       len_x10;
  logic [MSG_W:0]         count;
  logic                   too_long;
  logic                   header_end;
  logic [SUM_W-1:0]       len_wide;
  logic [SUM_W-1:0]       total;
  logic [MSG_W-1:0]       rem_dec;
  logic                   clear;
  logic                   body_last;

  assign b        = in_chan.data_byte;
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept   = in_chan.valid && in_chan.ready;
  assign is_digit = b inside {["0":"9"]};
  // The low nibble of an ASCII digit is its value.
  assign digit    = b[3:0];
  assign len_x10  = MUL_W'({len_r, 3'b000}) + MUL_W'({len_r, 1'b0}) + MUL_W'(digit);

  // Content-Length field scan for one header byte.
  always_comb begin
    sc_match  = match_r;
    sc_vphase = vphase_r;
    sc_len    = len_r;
    case (vphase_r)
      VP_NONE: begin
        if (match_r < KEY_LEN && b == key_char(match_r)) begin
          sc_match = match_r + 4'd1;
        end else begin
          sc_match = (b == key_char(4'd0)) ? 4'd1 : 4'd0;
        end
        if (sc_match >= KEY_LEN) begin
          sc_vphase = VP_BLANK;
          sc_match  = 4'd0;
        end
      end
      VP_BLANK: begin
        if (b == CH_SP || b == CH_TAB) begin
          sc_vphase = VP_BLANK;
        end else if (is_digit) begin
          sc_len    = LENGTH_BITS'(digit);
          sc_vphase = VP_DIGIT;
        end else begin
          sc_len    = '0;
          sc_vphase = VP_DONE;
        end
      end
      VP_DIGIT: begin
        if (is_digit) begin
          // Saturate once the value no longer fits the length register.
          sc_len = (len_x10[MUL_W-1:LENGTH_BITS] != '0) ? LEN_CAP
                                                         : len_x10[LENGTH_BITS-1:0];
        end else begin
          sc_vphase = VP_DONE;
        end
      end
      default: begin
        sc_vphase = vphase_r;
      end
    endcase
  end

  assign count      = {1'b0, count_r} + {{MSG_W{1'b0}}, 1'b1};
  assign too_long   = count > {1'b0, max_size_r};
  assign header_end = (recent_r == HDR_TAIL) && (b == CH_LF);
  assign len_wide   = SUM_W'(sc_len);
  assign total      = SUM_W'(count) + len_wide;
  assign rem_dec    = (rem_r != '0) ? rem_r - MSG_W'(1) : rem_r;

  always_comb begin
    recent_nxt  = recent_r;
    phase_nxt   = phase_r;
    match_nxt   = match_r;
    vphase_nxt  = vphase_r;
    len_nxt     = len_r;
    count_nxt   = count_r;
    rem_nxt     = rem_r;
    in_body_nxt = 1'b0;
    end_nxt     = 1'b0;
    err_nxt     = ERR_NONE;
    clear       = 1'b0;
    if (phase_r == PH_BODY) begin
      in_body_nxt = 1'b1;
      if (too_long) begin
        end_nxt = 1'b1;
        err_nxt = ERR_TOO_LONG;
        clear   = 1'b1;
      end else begin
        count_nxt = count[MSG_W-1:0];
        rem_nxt   = rem_dec;
        if (rem_dec == '0) begin
          end_nxt = 1'b1;
          clear   = 1'b1;
        end
      end
    end else if (too_long) begin
      end_nxt = 1'b1;
      err_nxt = ERR_TOO_LONG;
      clear   = 1'b1;
    end else begin
      count_nxt  = count[MSG_W-1:0];
      recent_nxt = {recent_r[15:0], b};
      match_nxt  = sc_match;
      vphase_nxt = sc_vphase;
      len_nxt    = sc_len;
      if (header_end) begin
        if (sc_vphase == VP_NONE || sc_vphase == VP_BLANK) begin
          end_nxt = 1'b1;
          err_nxt = ERR_NO_LEN;
          clear   = 1'b1;
        end else if (total > SUM_W'(max_size_r)) begin
          end_nxt = 1'b1;
          err_nxt = ERR_TOO_LONG;
          clear   = 1'b1;
        end else if (sc_len == '0) begin
          end_nxt = 1'b1;
          clear   = 1'b1;
        end else begin
          // The size check above bounds the length to the counter width.
          phase_nxt = PH_BODY;
          rem_nxt   = len_wide[MSG_W-1:0];
        end
      end
    end
    if (clear) begin
      recent_nxt = '0;
      phase_nxt  = PH_HDR;
      match_nxt  = '0;
      vphase_nxt = VP_NONE;
      len_nxt    = '0;
      count_nxt  = '0;
      rem_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= MAX_SIZE_RESET;
    end else if (cfg_wr_en) begin
      max_size_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r <= '0;
      phase_r  <= PH_HDR;
      match_r  <= '0;
      vphase_r <= VP_NONE;
      len_r    <= '0;
      count_r  <= '0;
      rem_r    <= '0;
    end else if (accept) begin
      recent_r <= recent_nxt;
      phase_r  <= phase_nxt;
      match_r  <= match_nxt;
      vphase_r <= vphase_nxt;
      len_r    <= len_nxt;
      count_r  <= count_nxt;
      rem_r    <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_byte_r <= b;
      in_body_r  <= in_body_nxt;
      end_r      <= end_nxt;
      err_r      <= err_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_byte    = out_byte_r;
  assign out_chan.in_body     = in_body_r;
  assign out_chan.message_end = end_r;
  assign out_chan.error_code  = err_r;

  assign body_last = accept && phase_r == PH_BODY && rem_r == MSG_W'(1);

`include "content_length_message_framer_unit_assert.svh"

  `CLMF_ASSERT_IMP(a_err_ends_msg, clk, rst_n, out_valid_r && err_r != ERR_NONE, end_r, "err")
  `CLMF_ASSERT_IMP(a_no_len_in_hdr, clk, rst_n, out_valid_r && err_r == ERR_NO_LEN, !in_body_r, "nolen")
  `CLMF_ASSERT_IMP(a_body_has_rem, clk, rst_n, phase_r == PH_BODY, rem_r != '0, "body rem")
  `CLMF_ASSERT_NXT(a_body_end_resets, clk, rst_n, body_last, phase_r == PH_HDR, "body end")

endmodule

FILE: sim/testbench.sv
module testbench;
  import clmf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int BYTES_PER_PHASE = 240;
  localparam int PHASE_COUNT = 8;
  localparam int unsigned LENGTH_CAP = 65535;
  localparam logic [8*15-1:0] FIELD_NAME = "Content-Length:";

  typedef struct packed {
    logic [7:0] data;
    logic       body;
    logic       last;
    err_t       err;
  } framed_byte_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [MSG_W-1:0] cfg_wr_data;

  clmf_in_if  in_bus();
  clmf_out_if out_bus();

  content_length_message_framer_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_bus),
    .out_chan    (out_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  logic [7:0]   pending_bytes[$];
  framed_byte_t expected_marks[$];
  int unsigned  send_idle_pct = 0;
  int unsigned  stall_pct = 0;
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  queued_count = 0;

  // Framer state as the block should hold it.
  logic [MSG_W-1:0] max_size;
  logic [23:0]      hdr_tail;
  logic [1:0]       parse_phase;
  logic [1:0]       field_state;
  logic [3:0]       key_pos;
  int unsigned      body_len;
  int unsigned      msg_count;
  int unsigned      body_left;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic void start_message();
    hdr_tail = '0;
    parse_phase = PH_HDR;
    key_pos = '0;
    field_state = VP_NONE;
    body_len = 0;
    msg_count = 0;
    body_left = 0;
  endfunction

  function automatic framed_byte_t frame_byte(input logic [7:0] b);
    framed_byte_t r;
    int unsigned  count;
    int unsigned  digit_val;
    logic         tail_hit;
    logic         is_digit;
    r.data = b;
    r.body = 1'b0;
    r.last = 1'b0;
    r.err = ERR_NONE;
    count = msg_count + 1;
    is_digit = (b >= CH_0) && (b <= CH_0 + 8'd9);
    digit_val = {28'd0, b[3:0]};
    if (parse_phase == PH_BODY) begin
      r.body = 1'b1;
      if (count > max_size) begin
        r.last = 1'b1;
        r.err = ERR_TOO_LONG;
        start_message();
      end else begin
        msg_count = count;
        if (body_left > 0) body_left--;
        if (body_left == 0) begin
          r.last = 1'b1;
          start_message();
        end
      end
    end else if (count > max_size) begin
      r.last = 1'b1;
      r.err = ERR_TOO_LONG;
      start_message();
    end else begin
      tail_hit = (hdr_tail == HDR_TAIL) && (b == CH_LF);
      msg_count = count;
      hdr_tail = {hdr_tail[15:0], b};
      case (field_state)
        VP_NONE: begin
          // A failed partial match may itself be the start of a new one.
          if (key_pos < KEY_LEN && b == FIELD_NAME[8*(14-int'(key_pos)) +: 8]) key_pos++;
          else key_pos = (b == FIELD_NAME[119 -: 8]) ? 4'd1 : 4'd0;
          if (key_pos >= KEY_LEN) begin
            field_state = VP_BLANK;
            key_pos = '0;
          end
        end
        VP_BLANK: begin
          if (b == CH_SP || b == CH_TAB) begin
          end else if (is_digit) begin
            body_len = digit_val;
            field_state = VP_DIGIT;
          end else begin
            body_len = 0;
            field_state = VP_DONE;
          end
        end
        VP_DIGIT: begin
          if (is_digit) begin
            body_len = body_len * 10 + digit_val;
            if (body_len > LENGTH_CAP) body_len = LENGTH_CAP;
          end else begin
            field_state = VP_DONE;
          end
        end
        default: begin
        end
      endcase
      if (tail_hit) begin
        if (field_state == VP_NONE || field_state == VP_BLANK) begin
          r.last = 1'b1;
          r.err = ERR_NO_LEN;
          start_message();
        end else if (count + body_len > max_size) begin
          r.last = 1'b1;
          r.err = ERR_TOO_LONG;
          start_message();
        end else if (body_len == 0) begin
          r.last = 1'b1;
          start_message();
        end else begin
          parse_phase = PH_BODY;
          body_left = body_len;
        end
      end
    end
    return r;
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    queued_count++;
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic void push_line_end();
    push_byte(CH_CR);
    push_byte(CH_LF);
  endfunction

  function automatic void push_blanks();
    repeat ($urandom_range(0, 3)) push_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
  endfunction

  function automatic void push_filler_line();
    repeat ($urandom_range(1, 10)) begin
      case ($urandom_range(0, 3))
        0: push_byte(8'($urandom_range(0, 255)));
        1: push_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
        default: push_byte(8'($urandom_range(8'h20, 8'h7E)));
      endcase
    end
    push_line_end();
  endfunction

  // One header and body, mostly well formed, sometimes broken or pure noise.
  task automatic queue_message();
    int kind;
    int declared;
    int body_bytes;
    kind = $urandom_range(0, 11);
    declared = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
    if (kind == 10) begin
      // Three-digit field keeps the header at 22 bytes, so the total lands on the limit or one byte past it.
      declared = int'(max_size) - 22 + int'($urandom_range(0, 1));
      if (declared < 0 || declared > 300) begin
        kind = 0;
        declared = $urandom_range(0, 12);
      end
    end
    if (kind == 11) begin
      repeat ($urandom_range(1, 30)) push_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (kind == 5 || (kind != 10 && $urandom_range(0, 1))) push_filler_line();
    case (kind)
      4: begin
        push_text("X-Content-Length:");
        push_blanks();
        push_text($sformatf("%0d", declared));
        push_line_end();
        push_text("Content-Length: 7");
        push_line_end();
      end
      5: begin
        declared = -1;
      end
      6: begin
        push_text("Content-Length:");
        push_blanks();
        case ($urandom_range(0, 3))
          0: push_text("-5");
          1: push_text("+3");
          2: push_text("x12");
          default: begin
          end
        endcase
        push_line_end();
        declared = 0;
      end
      7: begin
        push_text("Content-Length:");
        push_blanks();
        push_text($sformatf("%0d%0d", $urandom_range(1, 9999), $urandom_range(10000, 99999)));
        push_line_end();
        declared = -1;
      end
      8: begin
        push_text("ConContent-Length:");
        push_blanks();
        push_text($sformatf("%0d", declared));
        push_line_end();
      end
      9: begin
        case ($urandom_range(0, 2))
          0: push_text("content-length: 5");
          1: push_text("Content-Lengt: 5");
          default: push_text("Content-Length 5");
        endcase
        push_line_end();
        declared = -1;
      end
      10: begin
        push_text("Content-Length:");
        push_text($sformatf("%03d", declared));
        push_line_end();
      end
      default: begin
        push_text("Content-Length:");
        push_blanks();
        push_text($sformatf("%0d", declared));
        if ($urandom_range(0, 3) == 0) push_text(" 99");
        push_line_end();
      end
    endcase
    if (kind != 10 && $urandom_range(0, 3) == 0) push_filler_line();
    push_line_end();
    body_bytes = (declared < 0) ? 0 : declared;
    // A few messages carry the wrong amount of body.
    if ($urandom_range(0, 15) == 0) body_bytes = $urandom_range(0, 20);
    repeat (body_bytes) push_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_bus.valid || expected_marks.size() != 0)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Byte sender: a request is held until the block takes it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_bus.data_byte <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) expected_marks.push_back(frame_byte(in_bus.data_byte));
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_bus.valid <= 1'b1;
          in_bus.data_byte <= pending_bytes.pop_front();
        end else begin
          in_bus.valid <= 1'b0;
          in_bus.data_byte <= 8'($urandom_range(0, 255));
        end
      end
    end
  end

  always @(posedge clk) begin
    framed_byte_t got;
    framed_byte_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got = '{out_bus.out_byte, out_bus.in_body, out_bus.message_end, out_bus.error_code};
        if (expected_marks.size() == 0) begin
          error_count++;
          $display("%0t unexpected result: byte %h body %b end %b err %0d",
                   $time, got.data, got.body, got.last, got.err);
        end else begin
          want = expected_marks.pop_front();
          if (got.data !== want.data || got.body !== want.body || got.last !== want.last ||
              got.err !== want.err) begin
            error_count++;
            $display("%0t mismatch: expected %h/%b/%b/%0d, got %h/%b/%b/%0d",
                     $time, want.data, want.body, want.last, want.err,
                     got.data, got.body, got.last, got.err);
          end
        end
      end
      out_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    logic [MSG_W-1:0] setting;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_bus.valid = 1'b0;
    in_bus.data_byte = '0;
    out_bus.ready = 1'b0;
    max_size = MAX_SIZE_RESET;
    start_message();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Bare header end with no length, then a short body with extreme byte values.
    push_line_end();
    push_line_end();
    push_text("Content-Length:");
    push_byte(CH_TAB);
    push_byte(CH_SP);
    push_text("2");
    push_line_end();
    push_line_end();
    push_byte(8'h00);
    push_byte(8'hFF);

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      if (ph > 0) begin
        wait_idle();
        case (ph)
          1: setting = 16'd16;
          2: setting = 16'd65535;
          3: setting = 16'd200;
          4: setting = 16'($urandom_range(16, 65535));
          5: setting = 16'd40;
          6: setting = 16'($urandom_range(16, 400));
          default: setting = MAX_SIZE_RESET;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= setting;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        max_size = setting;
      end
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 58;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 58;
        end
        default: begin
          send_idle_pct = 21;
          stall_pct = 21;
        end
      endcase
      queued_count = 0;
      while (queued_count < BYTES_PER_PHASE) queue_message();
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
